### src/imrr_pkg.sv
`timescale 1ns / 1ps

package imrr_pkg;

    // Field and register widths.
    localparam int DATA_W    = 8;
    localparam int ACC_W     = 32;
    localparam int MULT_W    = 32;
    localparam int SHIFT_W   = 6;
    localparam int PROD_W    = ACC_W + MULT_W;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 32;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_MULT  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SCALE_SHIFT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RELU_EN     = 2'd2;

    // Reset values of the configuration registers.
    localparam logic [MULT_W-1:0]  MULT_RESET  = 32'd1;
    localparam logic [SHIFT_W-1:0] SHIFT_RESET = 6'd0;

    // Saturation bounds of the int8 result.
    localparam logic signed [PROD_W-1:0] SAT_MAX = 64'sd127;
    localparam logic signed [PROD_W-1:0] SAT_MIN = -64'sd128;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic acc_load;
        logic mul_load;
        logic out_load;
    } dp_cmd_t;

endpackage

### src/imrr_ctrl.sv
`timescale 1ns / 1ps

module imrr_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic             last,
    input  logic             out_ready,
    output logic             in_ready,
    output logic             out_valid,
    output imrr_pkg::dp_cmd_t cmd
);

    localparam logic [1:0] ST_ACCUM = 2'd0;
    localparam logic [1:0] ST_MUL   = 2'd1;
    localparam logic [1:0] ST_OUT   = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic       in_fire;
    logic       out_free;

    assign in_ready  = (state_reg == ST_ACCUM);
    assign in_fire   = in_valid && in_ready;
    assign out_free  = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;

    // Sequencing: accumulate pairs, then multiply, then round into the output register.
    always_comb
    begin
        state_next   = state_reg;
        cmd.acc_load = 1'b0;
        cmd.mul_load = 1'b0;
        cmd.out_load = 1'b0;
        case (state_reg)
            ST_ACCUM:
            begin
                cmd.acc_load = in_fire;
                if (in_fire && last)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                cmd.mul_load = 1'b1;
                state_next   = ST_OUT;
            end
            ST_OUT:
            begin
                // Wait here until the previous result has been taken.
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_ACCUM;
                end
            end
            default:
            begin
                state_next = ST_ACCUM;
            end
        endcase
    end

    // Output valid flag follows loads and completed transactions.
    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_ACCUM;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### src/imrr_dp.sv
`timescale 1ns / 1ps

module imrr_dp (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  imrr_pkg::dp_cmd_t                      cmd,
    input  logic                                   cfg_we,
    input  logic        [imrr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic        [imrr_pkg::CFG_DAT_W-1:0]  cfg_data,
    input  logic signed [imrr_pkg::DATA_W-1:0]     activation,
    input  logic signed [imrr_pkg::DATA_W-1:0]     weight_value,
    input  logic signed [imrr_pkg::ACC_W-1:0]      bias_value,
    input  logic                                   first,
    output logic signed [imrr_pkg::DATA_W-1:0]     result
);

    logic signed [imrr_pkg::ACC_W-1:0]    acc_reg;
    logic signed [imrr_pkg::ACC_W-1:0]    acc_next;
    logic signed [imrr_pkg::MULT_W-1:0]   mult_reg;
    logic        [imrr_pkg::SHIFT_W-1:0]  shift_reg;
    logic                                 relu_reg;
    logic signed [imrr_pkg::PROD_W-1:0]   prod_reg;
    logic signed [imrr_pkg::PROD_W-1:0]   prod_next;
    logic signed [2*imrr_pkg::DATA_W-1:0] pair_prod;
    logic        [imrr_pkg::SHIFT_W-1:0]  rnd_idx;
    logic signed [imrr_pkg::PROD_W-1:0]   shifted;
    logic signed [imrr_pkg::PROD_W-1:0]   rounded;
    logic signed [imrr_pkg::DATA_W-1:0]   result_reg;
    logic signed [imrr_pkg::DATA_W-1:0]   result_next;

    // Accumulate: a first item restarts from the bias; the sum wraps modulo 2^32.
    always_comb
    begin
        pair_prod = activation * weight_value;
        if (first)
        begin
            acc_next = bias_value + imrr_pkg::ACC_W'(pair_prod);
        end
        else
        begin
            acc_next = acc_reg + imrr_pkg::ACC_W'(pair_prod);
        end
    end

    // Exact 64-bit product of the sum and the scale multiplier.
    assign prod_next = imrr_pkg::PROD_W'(acc_reg) * imrr_pkg::PROD_W'(mult_reg);

    // Round half up, shift, saturate to int8, then optional ReLU.
    always_comb
    begin
        rnd_idx = shift_reg - imrr_pkg::SHIFT_W'(1);
        shifted = prod_reg >>> shift_reg;
        if (shift_reg != '0)
        begin
            rounded = shifted + imrr_pkg::PROD_W'({1'b0, prod_reg[rnd_idx]});
        end
        else
        begin
            rounded = prod_reg;
        end
        if (rounded > imrr_pkg::SAT_MAX)
        begin
            result_next = imrr_pkg::DATA_W'(imrr_pkg::SAT_MAX);
        end
        else if (rounded < imrr_pkg::SAT_MIN)
        begin
            result_next = imrr_pkg::DATA_W'(imrr_pkg::SAT_MIN);
        end
        else
        begin
            result_next = rounded[imrr_pkg::DATA_W-1:0];
        end
        if (relu_reg && result_next[imrr_pkg::DATA_W-1])
        begin
            result_next = '0;
        end
    end

    // Accumulator and configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg   <= '0;
            mult_reg  <= imrr_pkg::MULT_RESET;
            shift_reg <= imrr_pkg::SHIFT_RESET;
            relu_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.acc_load)
            begin
                acc_reg <= acc_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    imrr_pkg::CFG_SCALE_MULT:
                    begin
                        mult_reg <= cfg_data;
                    end
                    imrr_pkg::CFG_SCALE_SHIFT:
                    begin
                        shift_reg <= cfg_data[imrr_pkg::SHIFT_W-1:0];
                    end
                    imrr_pkg::CFG_RELU_EN:
                    begin
                        relu_reg <= cfg_data[0];
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // Pipeline payload registers.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            prod_reg <= prod_next;
        end
        if (cmd.out_load)
        begin
            result_reg <= result_next;
        end
    end

    assign result = result_reg;

endmodule

### src/int8_mac_requantize_relu.sv
`timescale 1ns / 1ps

// int8 dot product with fixed-point requantization and optional ReLU. Each
// accepted transaction carries one activation and weight pair, and pairs
// stream in back to back while the input is open. After the item marked
// last, the input pauses for the 32 x 32 multiply stage and then for the
// rounding, shift and saturation stage that loads the result register. The
// input pauses longer only if the previous result has not been taken yet.
// Registers must be written through the cfg port (0: scale multiplier, 1: scale
// shift, 2: ReLU enable) only while the block is idle; the block itself does
// not enforce this, and cfg_ready is always high.
module int8_mac_requantize_relu (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic        [imrr_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic        [imrr_pkg::CFG_DAT_W-1:0] cfg_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic signed [imrr_pkg::DATA_W-1:0]    activation,
    input  logic signed [imrr_pkg::DATA_W-1:0]    weight_value,
    input  logic signed [imrr_pkg::ACC_W-1:0]     bias_value,
    input  logic                                  first,
    input  logic                                  last,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [imrr_pkg::DATA_W-1:0]    result
);

    imrr_pkg::dp_cmd_t cmd;

    assign cfg_ready = 1'b1;

    imrr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .out_ready (out_ready),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    imrr_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .activation   (activation),
        .weight_value (weight_value),
        .bias_value   (bias_value),
        .first        (first),
        .result       (result)
    );

`ifndef SYNTHESIS
    // A last item closes the input for the multiply and rounding cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && last) |=> !in_ready ##1 !in_ready)
        else $error("input reopened before the result pipeline finished");

    // Items that do not end a dot product never pause the input.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && !last) |=> in_ready)
        else $error("input paused after an item that is not last");

    // A result becomes valid only after the input has stayed closed for the multiply and rounding cycles.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> !$past(in_ready) && !$past(in_ready, 2))
        else $error("result appeared without a completed dot product");
`endif

endmodule

### tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
    import imrr_pkg::*;

    localparam int RESET_CYCLES    = 11;
    localparam int SETTLE_CYCLES   = 6;
    localparam int DRAIN_LIMIT     = 2000;
    localparam int ITEMS_PER_PHASE = 250;
    localparam int NUM_PHASES      = 7;
    localparam time TIMEOUT_NS     = 5_000_000;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     cfg_valid = 1'b0;
    logic                     cfg_ready;
    logic [CFG_IDX_W-1:0]     cfg_index = '0;
    logic [CFG_DAT_W-1:0]     cfg_data = '0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic signed [DATA_W-1:0] activation = '0;
    logic signed [DATA_W-1:0] weight_value = '0;
    logic signed [ACC_W-1:0]  bias_value = '0;
    logic                     first = 1'b0;
    logic                     last = 1'b0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic signed [DATA_W-1:0] result;

    // Shadow copy of the block's state and scaling registers.
    logic [ACC_W-1:0]         acc_model = '0;
    logic signed [MULT_W-1:0] mult_model = MULT_RESET;
    logic [SHIFT_W-1:0]       shift_model = SHIFT_RESET;
    logic                     relu_model = 1'b0;

    // Requantized values still owed by the block, oldest first.
    logic signed [DATA_W-1:0] expected_results[$];
    logic signed [DATA_W-1:0] want;
    int unsigned              error_count = 0;
    bit                       quiet = 1'b0;

    int8_mac_requantize_relu dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .activation   (activation),
        .weight_value (weight_value),
        .bias_value   (bias_value),
        .first        (first),
        .last         (last),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .result       (result)
    );

    // 12 ns clock.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    task automatic report_error(input string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        error_count++;
    endtask

    // Scale the sum exactly in 64 bits, round half up, saturate, rectify.
    function automatic logic signed [DATA_W-1:0] requantized(input logic [ACC_W-1:0] sum);
        logic signed [PROD_W-1:0] sum64;
        logic signed [PROD_W-1:0] mult64;
        logic signed [PROD_W-1:0] prod;
        logic signed [PROD_W-1:0] val;
        sum64 = $signed(sum);
        mult64 = mult_model;
        prod = sum64 * mult64;
        if (shift_model != 0)
        begin
            val = prod >>> shift_model;
            if (prod[shift_model - 1])
                val = val + 64'sd1;
        end
        else
            val = prod;
        if (val > SAT_MAX)
            val = SAT_MAX;
        else if (val < SAT_MIN)
            val = SAT_MIN;
        if (relu_model && val < 0)
            val = '0;
        return val[DATA_W-1:0];
    endfunction

    // Send one activation/weight pair and record the result it owes.
    task automatic send_pair(input logic signed [DATA_W-1:0] act,
                             input logic signed [DATA_W-1:0] wt,
                             input logic [ACC_W-1:0] bias,
                             input logic f,
                             input logic l);
        logic signed [15:0] prod16;
        logic [ACC_W-1:0]   base;
        if (!quiet && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        activation   <= act;
        weight_value <= wt;
        bias_value   <= bias;
        first        <= f;
        last         <= l;
        in_valid     <= 1'b1;
        do @(posedge clk); while (!in_ready);
        prod16 = act * wt;
        base = f ? bias : acc_model;
        acc_model = base + {{16{prod16[15]}}, prod16};
        if (l)
            expected_results.push_back(requantized(acc_model));
    endtask

    // Hold the input until every owed result has arrived, then let the
    // pipeline settle.
    task automatic wait_for_results();
        int unsigned waited;
        in_valid <= 1'b0;
        waited = 0;
        while (expected_results.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        if (expected_results.size() != 0)
        begin
            report_error($sformatf("%0d expected results never arrived",
                                   expected_results.size()));
            expected_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        case (idx)
            CFG_SCALE_MULT:  mult_model = data;
            CFG_SCALE_SHIFT: shift_model = data[SHIFT_W-1:0];
            CFG_RELU_EN:     relu_model = data[0];
            default: ;
        endcase
    endtask

    // Valid stays high across the three writes and drops once at the end.
    task automatic set_scaling(input logic [MULT_W-1:0] mult,
                               input logic [SHIFT_W-1:0] shift,
                               input logic relu);
        write_reg(CFG_SCALE_MULT, mult);
        write_reg(CFG_SCALE_SHIFT, {{(CFG_DAT_W-SHIFT_W){1'b0}}, shift});
        write_reg(CFG_RELU_EN, {{(CFG_DAT_W-1){1'b0}}, relu});
        cfg_valid <= 1'b0;
    endtask

    // Accumulation starts from zero after reset and continues past a last.
    task automatic test_reset_state();
        send_pair(8'sd5, -8'sd7, 32'd123, 1'b0, 1'b1);
        send_pair(8'sd0, 8'sd0, 32'd0, 1'b0, 1'b1);
        send_pair(8'sd2, 8'sd3, 32'd0, 1'b0, 1'b1);
    endtask

    // Field extremes, one-pair dot products and accumulator wraparound.
    task automatic test_field_extremes();
        send_pair(-8'sd128, -8'sd128, 32'd0, 1'b1, 1'b1);
        send_pair(8'sd127, -8'sd128, 32'd0, 1'b1, 1'b1);
        send_pair(-8'sd128, -8'sd128, 32'h7fff_ffff, 1'b1, 1'b1);
        send_pair(8'sd127, -8'sd128, 32'h8000_0000, 1'b1, 1'b1);
        send_pair(8'sd127, 8'sd127, -32'sd16200, 1'b1, 1'b0);
        send_pair(-8'sd1, 8'sd127, 32'hffff_ffff, 1'b0, 1'b0);
        send_pair(8'sd0, 8'sd0, 32'd0, 1'b0, 1'b1);
        wait_for_results();
    endtask

    // Round half up with a one-bit shift: 1.5 -> 2, -1.5 -> -1, -0.5 -> 0.
    task automatic test_rounding();
        set_scaling(32'd1, 6'd1, 1'b0);
        send_pair(8'sd0, 8'sd0, 32'd3, 1'b1, 1'b1);
        send_pair(8'sd0, 8'sd0, -32'sd3, 1'b1, 1'b1);
        send_pair(8'sd0, 8'sd0, -32'sd1, 1'b1, 1'b1);
        send_pair(8'sd1, 8'sd1, 32'd0, 1'b1, 1'b1);
        wait_for_results();
    endtask

    // Largest products with the widest shift, ReLU, and a zero multiplier.
    task automatic test_scaling_extremes();
        set_scaling(32'h8000_0000, 6'd63, 1'b0);
        send_pair(8'sd0, 8'sd0, 32'h8000_0000, 1'b1, 1'b1);
        send_pair(8'sd0, 8'sd0, 32'h7fff_ffff, 1'b1, 1'b1);
        wait_for_results();
        set_scaling(32'h7fff_ffff, 6'd31, 1'b1);
        send_pair(-8'sd100, 8'sd1, 32'd0, 1'b1, 1'b1);
        send_pair(8'sd100, 8'sd1, 32'd0, 1'b1, 1'b1);
        wait_for_results();
        set_scaling(32'd0, 6'd0, 1'b1);
        send_pair(8'sd127, 8'sd127, 32'h7fff_ffff, 1'b1, 1'b1);
        wait_for_results();
    endtask

    // Random dot products under random scaling, with some malformed flags.
    task automatic test_random_traffic();
        int unsigned      phase;
        int unsigned      len;
        int unsigned      i;
        int unsigned      count;
        int unsigned      mag_bits;
        bit               paused;
        logic             f;
        logic             l;
        logic [MULT_W-1:0] mult;
        logic [SHIFT_W-1:0] shift;
        logic [ACC_W-1:0]  bias;
        logic [31:0]       r;
        paused = 1'b0;
        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            quiet = (phase == NUM_PHASES - 1);
            mag_bits = $urandom_range(0, 31);
            case ($urandom_range(0, 5))
                0: begin mult = 32'h8000_0000; mag_bits = 31; end
                1: begin mult = 32'h7fff_ffff; mag_bits = 31; end
                2: begin mult = $urandom; mag_bits = 31; end
                default:
                begin
                    mult = $urandom & (32'hffff_ffff >> (31 - mag_bits));
                    if ($urandom_range(0, 1))
                        mult = -mult;
                end
            endcase
            // Keep most shifts near the range where results do not saturate.
            case ($urandom_range(0, 7))
                0: shift = 6'd0;
                1: shift = 6'd63;
                default: shift = (mag_bits + $urandom_range(4, 14) > 63) ? 6'd63 :
                                 6'(mag_bits + $urandom_range(4, 14));
            endcase
            set_scaling(mult, shift, 1'($urandom_range(0, 1)));

            count = 0;
            while (count < ITEMS_PER_PHASE)
            begin
                len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
                r = $urandom;
                case ($urandom_range(0, 5))
                    0: bias = $urandom;
                    1: bias = r[0] ? 32'h7fff_ffff : 32'h8000_0000;
                    default: bias = {{16{r[15]}}, r[15:0]};
                endcase
                for (i = 0; i < len; i++)
                begin
                    f = (i == 0);
                    l = (i == len - 1);
                    if ($urandom_range(0, 11) == 0)
                    begin
                        f = 1'($urandom_range(0, 1));
                        l = 1'($urandom_range(0, 1));
                    end
                    send_pair(8'($urandom), 8'($urandom),
                              ($urandom_range(0, 3) == 0) ? $urandom : bias, f, l);
                end
                count += len;
                // Once, the sender holds off mid-phase until the output side catches up.
                if (phase == 2 && !paused && count >= ITEMS_PER_PHASE / 2)
                begin
                    wait_for_results();
                    paused = 1'b1;
                end
            end
            wait_for_results();
        end
    endtask

    // Compare each accepted result against the oldest prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_results.size() == 0)
                report_error($sformatf("unexpected result %0d", result));
            else
            begin
                want = expected_results.pop_front();
                if (result !== want)
                    report_error($sformatf("result %0d, expected %0d", result, want));
            end
        end
    end

    // Output side stalls in random bursts, none in the quiet part of the run.
    initial
    begin
        @(posedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 3) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 6)) @(posedge clk);
            end
            out_ready <= 1'b1;
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    end

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_field_extremes();
        test_rounding();
        test_scaling_extremes();
        test_random_traffic();
        wait_for_results();
        if (error_count == 0)
            $display("int8_mac_requantize_relu regression: pass");
        else
            $display("int8_mac_requantize_relu regression: fail");
        $finish;
    end

    // Watchdog against a hung handshake.
    initial
    begin
        #(TIMEOUT_NS);
        $display("[%0t] ERROR: timeout", $time);
        $display("int8_mac_requantize_relu regression: fail");
        $finish;
    end

endmodule
